// File: src/btm_pkg.sv
// ============================================================================
// btm_pkg: shared types and constants for the breakpoint table
// Holds the transfer payload structs, the command and status codes, and the
// control word that travels down the chain of table cells.
// ============================================================================
`default_nettype none

package btm_pkg;

    localparam int ADDR_W = 24;
    localparam int WORD_W = 16;

    // Trap instruction written over a breakpoint, and its length in bytes.
    localparam logic [WORD_W-1:0] TRAP_OPCODE = 16'h4E41;
    localparam int                TRAP_LENGTH = 2;

    typedef enum logic [2:0] {
        OP_SET       = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_CLEAR_ALL = 3'd2,
        OP_RESUME    = 3'd3,
        OP_ENTRY     = 3'd4
    } op_e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_e;

    typedef struct packed {
        logic [2:0]        op;
        logic [ADDR_W-1:0] target_addr;
        logic [WORD_W-1:0] mem_word;
        logic [ADDR_W-1:0] cpu_pc;
        logic              trace_flag;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              write_valid;
        logic [ADDR_W-1:0] write_addr;
        logic [WORD_W-1:0] write_data;
        logic [ADDR_W-1:0] new_pc;
        logic              new_trace;
        logic              keep_running;
        logic              last;
    } rsp_t;

    // Control word of the command token moving through the cells.
    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic       trace;
        logic       hit;
        logic       trap_hit;
        logic       drop_pend;
        logic       emitted;
    } tok_ctl_t;

endpackage

`default_nettype wire

// File: src/btm_cell.sv
// ============================================================================
// btm_cell: one breakpoint slot of the table
// Holds one address and its saved instruction word, acts on the command token
// as it passes and hands the updated token to the next slot.
// ============================================================================
`default_nettype none

module btm_cell
    import btm_pkg::*;
#(
    parameter int AW    = 24,
    parameter int IDX_W = 4,
    parameter int INDEX = 0
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              pend_valid,
    input  logic [IDX_W-1:0]  pend_idx,
    input  logic              later_used,
    input  tok_ctl_t          ctl_in,
    input  logic [AW-1:0]     addr_in,
    input  logic [AW-1:0]     pc_in,
    input  logic [WORD_W-1:0] word_in,
    input  logic [IDX_W-1:0]  idx_in,
    output tok_ctl_t          ctl_out,
    output logic [AW-1:0]     addr_out,
    output logic [AW-1:0]     pc_out,
    output logic [WORD_W-1:0] word_out,
    output logic [IDX_W-1:0]  idx_out,
    output logic              used,
    output logic              emit_valid,
    output rsp_t              emit
);

    logic [AW-1:0]     entry_reg;
    logic [AW-1:0]     entry_next;
    logic [WORD_W-1:0] saved_reg;
    logic              saved_we;
    tok_ctl_t          ctl_reg;
    tok_ctl_t          ctl_next;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;
    logic [AW-1:0]     pc_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              match;
    logic              pend_here;

    assign used      = (entry_reg != '0);
    // A free slot holds zero, so address zero can never match.
    assign match     = used && (entry_reg == addr_in);
    assign pend_here = pend_valid && (pend_idx == IDX_W'(INDEX));

    always_comb
    begin
        ctl_next   = ctl_in;
        addr_next  = addr_in;
        word_next  = word_in;
        idx_next   = idx_in;
        entry_next = entry_reg;
        saved_we   = 1'b0;
        emit_valid = 1'b0;
        emit       = '0;
        if (ctl_in.valid)
        begin
            case (ctl_in.op)
                OP_SET:
                begin
                    if (!ctl_in.hit && (addr_in != '0) && !used)
                    begin
                        ctl_next.hit = 1'b1;
                        idx_next     = IDX_W'(INDEX);
                        entry_next   = addr_in;
                        saved_we     = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    if (!ctl_in.hit && match)
                    begin
                        ctl_next.hit       = 1'b1;
                        idx_next           = IDX_W'(INDEX);
                        word_next          = saved_reg;
                        entry_next         = '0;
                        ctl_next.drop_pend = pend_here;
                    end
                end
                OP_CLEAR_ALL:
                begin
                    if (used)
                    begin
                        emit_valid        = 1'b1;
                        emit.status       = ST_OK;
                        emit.write_valid  = 1'b1;
                        emit.write_addr   = ADDR_W'(entry_reg);
                        emit.write_data   = saved_reg;
                        emit.new_pc       = ADDR_W'(pc_in);
                        emit.new_trace    = ctl_in.trace;
                        emit.keep_running = 1'b0;
                        emit.last         = !later_used;
                        entry_next        = '0;
                        ctl_next.emitted  = 1'b1;
                    end
                end
                OP_RESUME:
                begin
                    if (!ctl_in.hit && match)
                    begin
                        ctl_next.hit = 1'b1;
                        idx_next     = IDX_W'(INDEX);
                        word_next    = saved_reg;
                    end
                end
                OP_ENTRY:
                begin
                    if (used && (pc_in == entry_reg + AW'(TRAP_LENGTH)))
                    begin
                        ctl_next.trap_hit = 1'b1;
                    end
                    // The address field carries the pending slot's address on entry.
                    if (pend_here)
                    begin
                        addr_next = entry_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            ctl_reg   <= '0;
        end
        else if (adv)
        begin
            entry_reg <= entry_next;
            ctl_reg   <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr_reg <= addr_next;
            pc_reg   <= pc_in;
            word_reg <= word_next;
            idx_reg  <= idx_next;
        end
        if (adv && saved_we)
        begin
            saved_reg <= word_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign addr_out = addr_reg;
    assign pc_out   = pc_reg;
    assign word_out = word_reg;
    assign idx_out  = idx_reg;

endmodule

`default_nettype wire

// File: src/breakpoint_table_manager.sv
// ============================================================================
// breakpoint_table_manager: software breakpoint table
// Keeps a table of breakpoint slots as a chain of cells. A command token
// walks the chain one slot per cycle unless rsp stalls it, each slot acting on
// it in turn; the chain end forms the result and updates re-arm bookkeeping.
// ============================================================================
//
//   Channel   Direction  Handshake            Payload
//   cmd       in         cmd_valid/cmd_stall  cmd_t: op, target_addr, mem_word,
//                                             cpu_pc, trace_flag
//   rsp       out        rsp_valid/rsp_stall  rsp_t: status, write request,
//                                             new_pc, new_trace, keep_running,
//                                             last
//
// A command's result is formed as its token leaves the chain after the head
// register and the ENTRIES slot cells, and is then registered on rsp; the
// next command is taken the cycle after the token leaves the chain, so one
// command is in the chain at a time. Clear all yields one transfer per used
// slot as the token passes, and a stall on rsp while a result waits holds the
// whole chain, table contents included. Reset clears every slot to free and
// drops the pending re-arm; the saved words need no reset.
`default_nettype none

module breakpoint_table_manager
    import btm_pkg::*;
#(
    parameter int ENTRIES   = 12,
    parameter int ADDR_BITS = 24
)(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW    = ADDR_BITS;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Token links: index 0 is the head register, index k+1 the output of cell k.
    tok_ctl_t          ctl_link  [ENTRIES+1];
    logic [AW-1:0]     addr_link [ENTRIES+1];
    logic [AW-1:0]     pc_link   [ENTRIES+1];
    logic [WORD_W-1:0] word_link [ENTRIES+1];
    logic [IDX_W-1:0]  idx_link  [ENTRIES+1];

    logic [ENTRIES-1:0] used;
    logic [ENTRIES-1:0] later_used;
    logic [ENTRIES-1:0] emit_v;
    rsp_t               emit_arr [ENTRIES];

    // Head of the chain, loaded by a command transfer.
    tok_ctl_t          head_ctl_reg;
    tok_ctl_t          head_ctl_next;
    logic [AW-1:0]     head_addr_reg;
    logic [AW-1:0]     head_pc_reg;
    logic [WORD_W-1:0] head_word_reg;

    logic              busy_reg;
    logic              busy_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [IDX_W-1:0]  pend_idx_next;
    logic              was_tracing_reg;
    logic              was_tracing_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;

    logic              cmd_acc;
    logic [AW-1:0]     cmd_target;
    logic [AW-1:0]     cmd_pc;
    logic              adv;
    logic              out_free;
    logic              need_out;
    logic              emit_any;
    rsp_t              emit_sel;
    rsp_t              fin;
    logic              fin_needed;
    tok_ctl_t          exit_ctl;
    logic [AW-1:0]     exit_addr;
    logic [AW-1:0]     exit_pc;
    logic [AW-1:0]     entry_pc;

    assign cmd_stall = busy_reg;
    assign cmd_acc   = cmd_valid && !cmd_stall;

    // Addresses are reduced to ADDR_BITS; resume with address zero uses the PC.
    assign cmd_pc     = AW'(cmd.cpu_pc);
    assign cmd_target = ((cmd.op == OP_RESUME) && (AW'(cmd.target_addr) == '0)) ?
                        cmd_pc : AW'(cmd.target_addr);

    always_comb
    begin
        head_ctl_next = head_ctl_reg;
        if (cmd_acc)
        begin
            head_ctl_next       = '0;
            head_ctl_next.valid = 1'b1;
            head_ctl_next.op    = cmd.op;
            head_ctl_next.trace = cmd.trace_flag;
        end
        else if (adv)
        begin
            head_ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ctl_reg <= '0;
        end
        else
        begin
            head_ctl_reg <= head_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            head_addr_reg <= cmd_target;
            head_pc_reg   <= cmd_pc;
            head_word_reg <= cmd.mem_word;
        end
    end

    assign ctl_link[0]  = head_ctl_reg;
    assign addr_link[0] = head_addr_reg;
    assign pc_link[0]   = head_pc_reg;
    assign word_link[0] = head_word_reg;
    assign idx_link[0]  = '0;

    // The slot cells. Each one sees whether any higher slot is in use, which
    // tells clear all whether its restore is the final transfer.
    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        if (k == ENTRIES - 1)
        begin : g_top
            assign later_used[k] = 1'b0;
        end
        else
        begin : g_low
            assign later_used[k] = |used[ENTRIES-1:k+1];
        end

        btm_cell #(
            .AW    (AW),
            .IDX_W (IDX_W),
            .INDEX (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .pend_valid (pend_valid_reg),
            .pend_idx   (pend_idx_reg),
            .later_used (later_used[k]),
            .ctl_in     (ctl_link[k]),
            .addr_in    (addr_link[k]),
            .pc_in      (pc_link[k]),
            .word_in    (word_link[k]),
            .idx_in     (idx_link[k]),
            .ctl_out    (ctl_link[k+1]),
            .addr_out   (addr_link[k+1]),
            .pc_out     (pc_link[k+1]),
            .word_out   (word_link[k+1]),
            .idx_out    (idx_link[k+1]),
            .used       (used[k]),
            .emit_valid (emit_v[k]),
            .emit       (emit_arr[k])
        );
    end

    // Only one token is in flight, so at most one cell restores at a time.
    always_comb
    begin
        emit_sel = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (emit_v[k])
            begin
                emit_sel = emit_arr[k];
            end
        end
    end
    assign emit_any = |emit_v;

    assign exit_ctl  = ctl_link[ENTRIES];
    assign exit_addr = addr_link[ENTRIES];
    assign exit_pc   = pc_link[ENTRIES];
    // After a trap the PC sits just past the trap word; back it up.
    assign entry_pc  = exit_ctl.trap_hit ? (exit_pc - AW'(TRAP_LENGTH)) : exit_pc;

    // Result of the token leaving the chain, and the re-arm bookkeeping.
    always_comb
    begin
        fin              = '0;
        fin.status       = ST_OK;
        fin.new_pc       = ADDR_W'(exit_pc);
        fin.new_trace    = exit_ctl.trace;
        fin.last         = 1'b1;
        fin_needed       = 1'b0;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        was_tracing_next = was_tracing_reg;
        if (exit_ctl.valid)
        begin
            fin_needed = 1'b1;
            case (exit_ctl.op)
                OP_SET:
                begin
                    if (exit_addr != '0)
                    begin
                        if (exit_ctl.hit)
                        begin
                            fin.write_valid = 1'b1;
                            fin.write_addr  = ADDR_W'(exit_addr);
                            fin.write_data  = TRAP_OPCODE;
                        end
                        else
                        begin
                            fin.status = ST_FULL;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    if (exit_ctl.hit)
                    begin
                        fin.write_valid = 1'b1;
                        fin.write_addr  = ADDR_W'(exit_addr);
                        fin.write_data  = word_link[ENTRIES];
                        // A cleared slot must not be re-armed later.
                        if (exit_ctl.drop_pend)
                        begin
                            pend_valid_next = 1'b0;
                        end
                    end
                    else
                    begin
                        fin.status = ST_NOT_FOUND;
                    end
                end
                OP_CLEAR_ALL:
                begin
                    pend_valid_next = 1'b0;
                    if (exit_ctl.emitted)
                    begin
                        fin_needed = 1'b0;
                    end
                end
                OP_RESUME:
                begin
                    fin.new_pc = ADDR_W'(exit_addr);
                    if (exit_ctl.hit)
                    begin
                        pend_valid_next  = 1'b1;
                        pend_idx_next    = idx_link[ENTRIES];
                        was_tracing_next = exit_ctl.trace;
                        fin.write_valid  = 1'b1;
                        fin.write_addr   = ADDR_W'(exit_addr);
                        fin.write_data   = word_link[ENTRIES];
                        fin.new_trace    = 1'b1;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                    end
                end
                OP_ENTRY:
                begin
                    fin.new_pc    = ADDR_W'(entry_pc);
                    fin.new_trace = 1'b0;
                    if (pend_valid_reg)
                    begin
                        fin.write_valid  = 1'b1;
                        fin.write_addr   = ADDR_W'(exit_addr);
                        fin.write_data   = TRAP_OPCODE;
                        fin.keep_running = !was_tracing_reg;
                    end
                    pend_valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The chain moves unless it has a result to hand over and rsp is full.
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign need_out = emit_any || fin_needed;
    assign adv      = !need_out || out_free;

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd_acc)
        begin
            busy_next = 1'b1;
        end
        else if (exit_ctl.valid && adv)
        begin
            busy_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (adv && need_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_idx_reg    <= '0;
            was_tracing_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exit_ctl.valid && adv)
            begin
                pend_valid_reg  <= pend_valid_next;
                pend_idx_reg    <= pend_idx_next;
                was_tracing_reg <= was_tracing_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && need_out)
        begin
            rsp_reg <= emit_any ? emit_sel : fin;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: src/btm_checker.sv
// ============================================================================
// btm_checker: port-level checks for the breakpoint table
// Watches the result channel and checks how status, writes and the final
// marker relate over time.
// ============================================================================
`default_nettype none

module btm_checker
    import btm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A stalled result stays offered and unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // Failed set or clear never asks for a memory write and ends its command.
    a_fail_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> !rsp.write_valid && rsp.last)
        else $error("failing status with a write or not last");

    // Only clear all gives more than one result, each a restore write.
    a_not_last_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.write_valid && (rsp.status == ST_OK))
        else $error("non-final result without a restore write");

    // Continuing after entry only happens when a breakpoint was re-armed.
    a_keep_running: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.keep_running |->
            rsp.write_valid && (rsp.write_data == TRAP_OPCODE) && !rsp.new_trace)
        else $error("keep_running without a re-arm write");

    // Status codes stay within the defined set.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK) || (rsp.status == ST_FULL) ||
                      (rsp.status == ST_NOT_FOUND))
        else $error("undefined status code");

endmodule

bind breakpoint_table_manager btm_checker u_btm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// File: tb/sv/btm_table_checker.sv
// ============================================================================
// btm_table_checker: response checker for the breakpoint table
// Watches the cmd and rsp channels, keeps its own copy of the breakpoint
// slots and the re-arm state, and compares every response transfer with the
// oldest predicted reply.
// ============================================================================

module btm_table_checker
    import btm_pkg::*;
#(
    parameter int ENTRIES = 12
)(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_stall,
    input  cmd_t cmd,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   errors,
    output int   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow breakpoint table and re-arm bookkeeping.
    logic [ADDR_W-1:0] slot_addr [ENTRIES];
    logic [WORD_W-1:0] slot_word [ENTRIES];
    logic              rearm_pending;
    int                rearm_slot;
    logic              rearm_traced;

    // Replies the table owes, oldest first.
    rsp_t table_replies [$];

    // Lowest slot holding addr; address zero never matches.
    function automatic int find_slot(input logic [ADDR_W-1:0] addr);
        int hit;
        hit = -1;
        if (addr != '0) begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (slot_addr[i] == addr) hit = i;
            end
        end
        return hit;
    endfunction

    task automatic apply_table_command(input cmd_t c);
        rsp_t              r;
        int                idx;
        int                used;
        int                emitted;
        logic [ADDR_W-1:0] resume_pc;
        logic [ADDR_W-1:0] trap_pc;
        r = '0;
        r.status    = ST_OK;
        r.new_pc    = c.cpu_pc;
        r.new_trace = c.trace_flag;
        r.last      = 1'b1;
        case (c.op)
            OP_SET: begin
                if (c.target_addr != '0) begin
                    idx = -1;
                    for (int i = ENTRIES - 1; i >= 0; i--) begin
                        if (slot_addr[i] == '0) idx = i;
                    end
                    if (idx < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        slot_addr[idx] = c.target_addr;
                        slot_word[idx] = c.mem_word;
                        r.write_valid  = 1'b1;
                        r.write_addr   = c.target_addr;
                        r.write_data   = TRAP_OPCODE;
                    end
                end
                table_replies.push_back(r);
            end
            OP_CLEAR: begin
                idx = find_slot(c.target_addr);
                if (idx < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    slot_addr[idx] = '0;
                    if (rearm_pending && rearm_slot == idx) rearm_pending = 1'b0;
                    r.write_valid = 1'b1;
                    r.write_addr  = c.target_addr;
                    r.write_data  = slot_word[idx];
                end
                table_replies.push_back(r);
            end
            OP_CLEAR_ALL: begin
                used = 0;
                emitted = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_addr[i] != '0) used++;
                end
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_addr[i] != '0) begin
                        emitted++;
                        r.write_valid = 1'b1;
                        r.write_addr  = slot_addr[i];
                        r.write_data  = slot_word[i];
                        r.last        = (emitted == used);
                        table_replies.push_back(r);
                        slot_addr[i] = '0;
                    end
                end
                rearm_pending = 1'b0;
                if (used == 0) table_replies.push_back(r);
            end
            OP_RESUME: begin
                resume_pc = (c.target_addr != '0) ? c.target_addr : c.cpu_pc;
                r.new_pc  = resume_pc;
                idx = find_slot(resume_pc);
                if (idx < 0) begin
                    rearm_pending = 1'b0;
                end else begin
                    rearm_pending = 1'b1;
                    rearm_slot    = idx;
                    rearm_traced  = c.trace_flag;
                    r.write_valid = 1'b1;
                    r.write_addr  = resume_pc;
                    r.write_data  = slot_word[idx];
                    r.new_trace   = 1'b1;
                end
                table_replies.push_back(r);
            end
            OP_ENTRY: begin
                r.new_trace = 1'b0;
                idx = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    trap_pc = slot_addr[i] + ADDR_W'(TRAP_LENGTH);
                    if (idx < 0 && slot_addr[i] != '0 && c.cpu_pc == trap_pc) idx = i;
                end
                // The PC after a trap points past the trap opcode; back it up.
                if (idx >= 0) r.new_pc = c.cpu_pc - ADDR_W'(TRAP_LENGTH);
                if (rearm_pending) begin
                    r.write_valid  = 1'b1;
                    r.write_addr   = slot_addr[rearm_slot];
                    r.write_data   = TRAP_OPCODE;
                    r.keep_running = ~rearm_traced;
                end
                rearm_pending = 1'b0;
                table_replies.push_back(r);
            end
            default: begin
                table_replies.push_back(r);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("rsp.%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_addr[i] = '0;
                slot_word[i] = '0;
            end
            rearm_pending = 1'b0;
            rearm_slot    = 0;
            rearm_traced  = 1'b0;
            table_replies.delete();
            errors      = 0;
            outstanding = 0;
        end else begin
            // A reply never leaves in the cycle its own command arrives, so the
            // response side is checked first.
            if (rsp_valid && !rsp_stall) begin
                if (table_replies.size() == 0) begin
                    $error("unexpected rsp transfer: status %0d write %0b addr 0x%0h",
                           rsp.status, rsp.write_valid, rsp.write_addr);
                    errors++;
                end else begin
                    want = table_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("write_valid", 32'(want.write_valid), 32'(rsp.write_valid));
                    check_field("write_addr", 32'(want.write_addr), 32'(rsp.write_addr));
                    check_field("write_data", 32'(want.write_data), 32'(rsp.write_data));
                    check_field("new_pc", 32'(want.new_pc), 32'(rsp.new_pc));
                    check_field("new_trace", 32'(want.new_trace), 32'(rsp.new_trace));
                    check_field("keep_running", 32'(want.keep_running),
                                32'(rsp.keep_running));
                    check_field("last", 32'(want.last), 32'(rsp.last));
                end
            end
            if (cmd_valid && !cmd_stall) apply_table_command(cmd);
            outstanding = table_replies.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// ============================================================================
// tb_top: testbench for the breakpoint table manager
// Drives debugger commands and monitor entries into the table, first a
// directed set of corner cases, then random debug sessions built around a
// small pool of breakpoint addresses. A checker beside the block predicts
// every response transfer; this module gives the verdict.
// ============================================================================

module tb_top
    import btm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 12;

    // Number of commands after which the random session stops.
    localparam int ITEM_TARGET = 460;

    // Longest run of consecutive stall cycles on the response side.
    localparam int MAX_STALL_RUN = 8;

    // Cycles without any transfer before the run is declared hung. The slowest
    // correct gap between two transfers is a sender pause plus the walk of a
    // command through the slots plus a full stall run.
    localparam int IDLE_LIMIT = 2000;

    // Op codes the block does not define; they must pass through harmlessly.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int errors;
    int outstanding;

    // Sender bookkeeping: commands still to go in the current burst, and the
    // number of commands accepted so far.
    int burst_left;
    int items_sent;

    // Breakpoint addresses that the random sessions keep coming back to, so
    // that set, clear, resume and trap entry meet the same slots.
    logic [ADDR_W-1:0] addr_pool [16];

    breakpoint_table_manager #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    btm_table_checker #(
        .ENTRIES (ENTRIES)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The response side stalls on a pattern of its own: it switches at random
    // between no stall at all and light, heavy and nearly constant stalling,
    // but never holds a stall longer than MAX_STALL_RUN.
    initial begin : rsp_stall_pattern
        int phase_cycles;
        int stall_pct;
        int stall_run;
        rsp_stall = 1'b0;
        phase_cycles = 0;
        stall_pct = 0;
        stall_run = 0;
        forever begin
            @(posedge clk);
            if (phase_cycles == 0) begin
                phase_cycles = $urandom_range(20, 300);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            phase_cycles--;
            if (stall_run >= MAX_STALL_RUN || $urandom_range(0, 99) >= stall_pct) begin
                rsp_stall <= 1'b0;
                stall_run = 0;
            end else begin
                rsp_stall <= 1'b1;
                stall_run++;
            end
        end
    end

    // Ends the run if neither channel has moved a transfer for too long.
    initial begin : idle_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Offers one command and waits for the edge where it is accepted. The
    // sender works in bursts: when a burst runs out, valid drops for a random
    // pause (sometimes none) and a new burst length is drawn.
    task automatic send_item(input logic [2:0] op, input logic [ADDR_W-1:0] target,
                             input logic [WORD_W-1:0] word,
                             input logic [ADDR_W-1:0] pc, input logic trace);
        cmd_t item;
        int   gap;
        item.op          = op;
        item.target_addr = target;
        item.mem_word    = word;
        item.cpu_pc      = pc;
        item.trace_flag  = trace;
        cmd       <= item;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 24);
        end
    endtask

    function automatic logic [ADDR_W-1:0] any_addr();
        return ADDR_W'($urandom());
    endfunction

    function automatic logic [WORD_W-1:0] any_word();
        return WORD_W'($urandom());
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    initial begin : stimulus
        logic [ADDR_W-1:0] bp_addr;
        logic [ADDR_W-1:0] trap_pc;
        int                pick;

        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        burst_left = 0;
        items_sent = 0;
        addr_pool[0] = 24'hFFFFFF;
        addr_pool[1] = 24'hFFFFFE;
        addr_pool[2] = 24'h000001;
        for (int i = 3; i < 16; i++) addr_pool[i] = any_addr();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- Directed corner cases ----------------
        // Clear all on an empty table answers once, with no write.
        send_item(OP_CLEAR_ALL, '0, '0, '0, 1'b0);
        // A set of address zero is ignored.
        send_item(OP_SET, '0, 16'hFFFF, 24'hFFFFFF, 1'b1);
        // Next to the top of the address space, with an all-ones saved word.
        send_item(OP_SET, 24'hFFFFFE, 16'hFFFF, '0, 1'b0);
        // The same address twice takes two slots.
        send_item(OP_SET, 24'h000002, 16'h0000, 24'h000100, 1'b1);
        send_item(OP_SET, 24'h000002, 16'h1234, 24'h000100, 1'b0);
        // Fill the rest of the table, then one more set must report full.
        for (int k = 0; k < ENTRIES - 3; k++)
            send_item(OP_SET, ADDR_W'($urandom_range(1, 24'hFFFFFF)), any_word(),
                      any_addr(), any_bit());
        send_item(OP_SET, 24'h00ABCD, 16'h5A5A, 24'h00ABCD, 1'b0);
        // Clear of a duplicate frees the lower slot; the other stays armed.
        send_item(OP_CLEAR, 24'h000002, any_word(), 24'h000200, 1'b0);
        // Address zero never matches a slot.
        send_item(OP_CLEAR, '0, any_word(), 24'h000200, 1'b0);
        // Resume with target zero uses the PC; the trap after it wraps the PC
        // through zero when backing up, and re-arms with keep_running set.
        send_item(OP_RESUME, '0, any_word(), 24'hFFFFFE, 1'b0);
        send_item(OP_ENTRY, any_addr(), any_word(), 24'h000000, 1'b1);
        // A pending slot that is cleared must not be re-armed.
        send_item(OP_RESUME, 24'h000002, any_word(), '0, 1'b1);
        send_item(OP_CLEAR, 24'h000002, any_word(), 24'h000002, 1'b1);
        send_item(OP_ENTRY, '0, any_word(), 24'h000004, 1'b0);
        // Resume while the user was tracing: the entry does not keep running.
        send_item(OP_RESUME, 24'hFFFFFE, any_word(), 24'h123456, 1'b1);
        send_item(OP_ENTRY, '0, any_word(), 24'h000000, 1'b1);
        // Resume at an address with no slot just loads the PC.
        send_item(OP_RESUME, 24'hABCDEF, any_word(), 24'h000010, 1'b1);
        // An undefined op code with every field at all ones.
        send_item(OP_UNUSED_LAST, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1);
        // Clear all with many used slots yields one transfer per slot.
        send_item(OP_CLEAR_ALL, any_addr(), any_word(), any_addr(), 1'b1);

        // ---------------- Random debug sessions ----------------
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0)
                addr_pool[$urandom_range(0, 15)] = any_addr();
            bp_addr = addr_pool[$urandom_range(0, 15)];
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_item(OP_SET, bp_addr, any_word(), any_addr(), any_bit());
            end else if (pick < 45) begin
                if ($urandom_range(0, 99) < 85)
                    send_item(OP_CLEAR, bp_addr, any_word(), any_addr(), any_bit());
                else
                    send_item(OP_CLEAR, any_addr(), any_word(), any_addr(), any_bit());
            end else if (pick < 75) begin
                // A breakpoint hit: trap entry just past the trap opcode, resume
                // from the breakpoint, sometimes a clear of it, then the trace
                // trap two to eight bytes on, which re-arms it if it is still set.
                trap_pc = bp_addr + ADDR_W'(TRAP_LENGTH);
                send_item(OP_ENTRY, any_addr(), any_word(), trap_pc, any_bit());
                if (any_bit())
                    send_item(OP_RESUME, '0, any_word(), bp_addr, any_bit());
                else
                    send_item(OP_RESUME, bp_addr, any_word(), any_addr(), any_bit());
                if ($urandom_range(0, 99) < 20)
                    send_item(OP_CLEAR, bp_addr, any_word(), any_addr(), any_bit());
                trap_pc = bp_addr + ADDR_W'($urandom_range(2, 8));
                send_item(OP_ENTRY, any_addr(), any_word(), trap_pc, 1'b1);
            end else if (pick < 80) begin
                send_item(OP_RESUME, any_addr(), any_word(), any_addr(), any_bit());
                send_item(OP_ENTRY, any_addr(), any_word(), any_addr(), any_bit());
            end else if (pick < 84) begin
                send_item(OP_CLEAR_ALL, any_addr(), any_word(), any_addr(), any_bit());
            end else if (pick < 87) begin
                send_item(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                          bp_addr, any_word(), any_addr(), any_bit());
            end else begin
                // Noise: any op code and fully random fields.
                send_item(3'($urandom_range(0, 7)), any_bit() ? bp_addr : any_addr(),
                          any_word(), any_addr(), any_bit());
            end
        end

        cmd_valid <= 1'b0;

        // Wait for every owed response transfer, then give the chain time to
        // show any response that should not be there.
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (ENTRIES + 8) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
